[rtl/kes_pkg.sv]
// Package for the key event scanner: result and lane types, register
// indexes, reset values and the saturating counter add. No dependencies.
package kes_pkg;

  localparam int unsigned KEY_W    = 8;
  localparam int unsigned TICK_W   = 10;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESH = 2'd2;

  localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 10'd10;
  localparam logic [CNT_W-1:0]  DEBOUNCE_RST    = 16'd0;
  localparam logic [CNT_W-1:0]  HOLD_THRESH_RST = 16'd500;
  localparam logic [CNT_W-1:0]  CNT_SAT         = 16'hFFFF;

  typedef struct packed {
    logic [TICK_W-1:0] tick_period;
    logic [CNT_W-1:0]  debounce;
    logic [CNT_W-1:0]  hold_thresh;
  } kes_cfg_t;

  typedef struct packed {
    logic pressed;
    logic released;
    logic hold_entry;
    logic held;
  } kes_lane_evt_t;

  typedef struct packed {
    logic [KEY_W-1:0] pressed_mask;
    logic [KEY_W-1:0] released_mask;
    logic [KEY_W-1:0] hold_start_mask;
    logic [KEY_W-1:0] down_mask;
    logic [KEY_W-1:0] idle_mask;
    logic [KEY_W-1:0] held_mask;
  } kes_result_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [TICK_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {{(CNT_W + 1 - TICK_W){1'b0}}, b};
    return sum[CNT_W] ? CNT_SAT : sum[CNT_W-1:0];
  endfunction

endpackage

[rtl/kes_in_if.sv]
// Request channel into the key event scanner: one raw key sample.
// Depends on kes_pkg for the field width.
interface kes_in_if;
  logic                     valid;
  logic                     ready;
  logic [kes_pkg::KEY_W-1:0] raw_keys;

  modport source (output valid, output raw_keys, input ready);
  modport sink   (input valid, input raw_keys, output ready);
endinterface

[rtl/kes_out_if.sv]
// Result channel out of the key event scanner: six key masks.
// Depends on kes_pkg for the field width.
interface kes_out_if;
  logic                     valid;
  logic                     ready;
  logic [kes_pkg::KEY_W-1:0] pressed_mask;
  logic [kes_pkg::KEY_W-1:0] released_mask;
  logic [kes_pkg::KEY_W-1:0] hold_start_mask;
  logic [kes_pkg::KEY_W-1:0] down_mask;
  logic [kes_pkg::KEY_W-1:0] idle_mask;
  logic [kes_pkg::KEY_W-1:0] held_mask;

  modport source (output valid, output pressed_mask, output released_mask,
                  output hold_start_mask, output down_mask, output idle_mask,
                  output held_mask, input ready);
  modport sink   (input valid, input pressed_mask, input released_mask,
                  input hold_start_mask, input down_mask, input idle_mask,
                  input held_mask, output ready);
endinterface

[rtl/kes_lane.sv]
// One key lane: edge detect, debounce stable timer, hold timer and hold flag.
// Depends on kes_pkg for the configuration and event types.
module kes_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              down,
  input  kes_pkg::kes_cfg_t cfg,
  output kes_pkg::kes_lane_evt_t evt
);

  logic                       last_r, last_nxt;
  logic                       flag_r, flag_nxt;
  logic [kes_pkg::CNT_W-1:0]  stable_r, stable_nxt;
  logic [kes_pkg::CNT_W-1:0]  hold_r, hold_nxt;
  logic [kes_pkg::CNT_W-1:0]  hold_base;
  logic                       changed;
  logic                       flag_base;
  logic                       accrue;
  logic                       start;

  always_comb begin
    changed  = down ^ last_r;
    last_nxt = down;
    if (cfg.debounce == '0) begin
      stable_nxt = down ? kes_pkg::CNT_SAT : '0;
    end else if (!changed) begin
      stable_nxt = down ? kes_pkg::sat_add(stable_r, cfg.tick_period) : '0;
    end else begin
      stable_nxt = down ? {{(kes_pkg::CNT_W - kes_pkg::TICK_W){1'b0}}, cfg.tick_period}
                        : '0;
    end
    hold_base = changed ? '0 : hold_r;
    flag_base = (changed && !down) ? 1'b0 : flag_r;
    accrue    = down && (stable_nxt >= cfg.debounce);
    hold_nxt  = accrue ? kes_pkg::sat_add(hold_base, cfg.tick_period) : hold_base;
    start     = accrue && !flag_base && (hold_nxt >= cfg.hold_thresh);
    flag_nxt  = flag_base | start;

    evt.pressed    = changed & down;
    evt.released   = changed & ~down;
    evt.hold_entry = start;
    evt.held       = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= 1'b0;
      flag_r   <= 1'b0;
      stable_r <= '0;
      hold_r   <= '0;
    end else if (step) begin
      last_r   <= last_nxt;
      flag_r   <= flag_nxt;
      stable_r <= stable_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

[rtl/kes_merge.sv]
// Merges the lane events into the result masks and holds them in a
// two-entry output buffer. Depends on kes_pkg.
module kes_merge #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [kes_pkg::KEY_W-1:0]     raw_keys,
  input  kes_pkg::kes_lane_evt_t        evt [NUM_KEYS],
  output logic                          has_room,
  output logic                          res_valid,
  input  logic                          res_ready,
  output kes_pkg::kes_result_t          res
);

  kes_pkg::kes_result_t merged;
  kes_pkg::kes_result_t out_r, out_nxt;
  kes_pkg::kes_result_t skid_r, skid_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  logic                 pop;

  always_comb begin
    merged           = '0;
    merged.down_mask = raw_keys;
    merged.idle_mask = ~raw_keys;
    for (int k = 0; k < kes_pkg::KEY_W; k++) begin
      if (k < NUM_KEYS) begin
        merged.pressed_mask[k]    = evt[k].pressed;
        merged.released_mask[k]   = evt[k].released;
        merged.hold_start_mask[k] = evt[k].hold_entry;
        merged.held_mask[k]       = evt[k].held;
      end
    end
  end

  assign pop       = out_v_r & res_ready;
  assign has_room  = ~skid_v_r;
  assign res_valid = out_v_r;
  assign res       = out_r;

  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_nxt   = merged;
      end
    end else if (push) begin
      if (out_v_r) begin
        skid_nxt   = merged;
        skid_v_nxt = 1'b1;
      end else begin
        out_nxt   = merged;
        out_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[rtl/key_event_scanner_core.sv]
// Top level of the key event scanner: configuration registers, one lane per
// key and the merging output stage. Depends on kes_pkg, kes_in_if,
// kes_out_if, kes_lane and kes_merge.
//
//   channel   direction  handshake          payload
//   in_chan   in         valid/ready        raw_keys
//   out_chan  out        valid/ready        pressed, released, hold_start,
//                                           down, idle, held masks
//   cfg_*     in         cfg_we, no ready   cfg_index, cfg_wdata
//
// Each result is registered in a two-entry output buffer, which lets one more
// request in while a result is stalled. All key lanes update in parallel in
// the accepting cycle, so the rate is one sample per clock unless both entries
// are full; in_chan.ready drops only then. Synchronous reset clears all
// counters and flags.
module key_event_scanner_core #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kes_in_if.sink                        in_chan,
  kes_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [kes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kes_pkg::CFG_W-1:0]     cfg_wdata
);

  kes_pkg::kes_cfg_t      cfg_r, cfg_nxt;
  kes_pkg::kes_lane_evt_t evt [NUM_KEYS];
  kes_pkg::kes_result_t   res;
  logic                   push;
  logic                   has_room;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        kes_pkg::REG_TICK_PERIOD: cfg_nxt.tick_period = cfg_wdata[kes_pkg::TICK_W-1:0];
        kes_pkg::REG_DEBOUNCE:    cfg_nxt.debounce    = cfg_wdata;
        kes_pkg::REG_HOLD_THRESH: cfg_nxt.hold_thresh = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period <= kes_pkg::TICK_PERIOD_RST;
      cfg_r.debounce    <= kes_pkg::DEBOUNCE_RST;
      cfg_r.hold_thresh <= kes_pkg::HOLD_THRESH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_chan.ready = has_room;
  assign push          = in_chan.valid & has_room;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic down;
    if (k < kes_pkg::KEY_W) begin : g_real
      assign down = in_chan.raw_keys[k];
    end else begin : g_absent
      assign down = 1'b0;
    end
    kes_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (push),
      .down  (down),
      .cfg   (cfg_r),
      .evt   (evt[k])
    );
  end

  kes_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .raw_keys  (in_chan.raw_keys),
    .evt       (evt),
    .has_room  (has_room),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res       (res)
  );

  assign out_chan.pressed_mask    = res.pressed_mask;
  assign out_chan.released_mask   = res.released_mask;
  assign out_chan.hold_start_mask = res.hold_start_mask;
  assign out_chan.down_mask       = res.down_mask;
  assign out_chan.idle_mask       = res.idle_mask;
  assign out_chan.held_mask       = res.held_mask;

endmodule

[rtl/kes_checker.sv]
// Port-level checks for the key event scanner, bound to its top level.
// Depends on key_event_scanner_core and kes_pkg.
module kes_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [kes_pkg::KEY_W-1:0] pressed_mask,
  input logic [kes_pkg::KEY_W-1:0] released_mask,
  input logic [kes_pkg::KEY_W-1:0] hold_start_mask,
  input logic [kes_pkg::KEY_W-1:0] down_mask,
  input logic [kes_pkg::KEY_W-1:0] idle_mask,
  input logic [kes_pkg::KEY_W-1:0] held_mask
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pressed_mask)
      && $stable(held_mask) && $stable(down_mask))
    else $error("result changed while stalled");

  a_idle_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idle_mask == ~down_mask)
    else $error("idle mask is not the inverse of down mask");

  a_edge_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pressed_mask & ~down_mask) == '0 && (released_mask & down_mask) == '0)
    else $error("edge mask disagrees with key level");

  a_hold_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (hold_start_mask & ~(held_mask & down_mask)) == '0)
    else $error("hold start on a key not held and down");

endmodule

bind key_event_scanner_core kes_checker u_kes_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .pressed_mask    (out_chan.pressed_mask),
  .released_mask   (out_chan.released_mask),
  .hold_start_mask (out_chan.hold_start_mask),
  .down_mask       (out_chan.down_mask),
  .idle_mask       (out_chan.idle_mask),
  .held_mask       (out_chan.held_mask)
);
